>>> rtl/vfm_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the voxel face culling mesher.
package vfm_pkg;

  localparam int POS_W    = 4;
  localparam int SIDE_W   = 3;
  localparam int BLK_W    = 8;
  localparam int VTX_W    = 17;
  localparam int NUM_DIRS = 6;

  // Vertex counter advances by the four corners of one quad.
  localparam logic [VTX_W-1:0] VTX_STEP = 17'd4;

  // Face directions, also used as neighbour chunk sides.
  localparam logic [SIDE_W-1:0] DIR_NORTH  = 3'd0;
  localparam logic [SIDE_W-1:0] DIR_SOUTH  = 3'd1;
  localparam logic [SIDE_W-1:0] DIR_WEST   = 3'd2;
  localparam logic [SIDE_W-1:0] DIR_EAST   = 3'd3;
  localparam logic [SIDE_W-1:0] DIR_BOTTOM = 3'd4;
  localparam logic [SIDE_W-1:0] DIR_TOP    = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD_CELL = 2'd0,
    OP_LOAD_NB   = 2'd1,
    OP_MESH      = 2'd2,
    OP_BEGIN     = 2'd3
  } opcode_t;

  // Which group of cells a read cycle fetches.
  typedef enum logic [1:0] {
    RD_CENTER = 2'd0,
    RD_NS     = 2'd1,
    RD_WE     = 2'd2,
    RD_BT     = 2'd3
  } rd_sel_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [SIDE_W-1:0] side;
    logic [BLK_W-1:0]  block_value;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  face_x;
    logic [POS_W-1:0]  face_y;
    logic [POS_W-1:0]  face_z;
    logic [SIDE_W-1:0] face_dir;
    logic [BLK_W-1:0]  block_type;
    logic [VTX_W-1:0]  base_vertex;
    logic              last_face;
  } face_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mesh_req;
    logic pending;
    logic single;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/vfm_datapath.sv
`timescale 1ns / 1ps
// Datapath of the mesher: cell and border stores, neighbour reads, face mask and output word.
module vfm_datapath #(
  parameter int CHUNK_SIZE = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  vfm_pkg::cmd_t   cmd,
  input  vfm_pkg::ctl_t   ctl,
  output vfm_pkg::sts_t   sts,
  output vfm_pkg::face_t  face,
  output logic            face_valid,
  input  logic            face_stall
);
  import vfm_pkg::*;

  localparam int N      = CHUNK_SIZE;
  localparam int NN     = N * N;
  localparam int CELLS  = NN * N;
  localparam int BCELLS = NUM_DIRS * NN;
  localparam int AW     = $clog2(CELLS);
  localparam int BW     = $clog2(BCELLS);
  localparam int CW     = POS_W + 1;
  localparam logic [CW:0]   N_C   = (CW + 1)'(N);
  localparam logic [CW-1:0] TOP_C = CW'(N - 1);

  function automatic logic [AW-1:0] cube_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    return AW'(int'(x) * NN + int'(z) * N + int'(y));
  endfunction

  function automatic logic [BW-1:0] layer_addr(input logic [SIDE_W-1:0] s,
                                               input logic [CW-1:0]     a,
                                               input logic [CW-1:0]     b);
    return BW'(int'(s) * NN + int'(a) * N + int'(b));
  endfunction

  logic [BLK_W-1:0] cell_mem [CELLS];
  logic [BLK_W-1:0] bd_mem   [BCELLS];

  logic [CW-1:0]       in_x, in_y, in_z;
  logic                in_chunk;
  logic                cell_we, bd_we, on_layer;
  logic [CW-1:0]       ly_a, ly_b;
  logic [POS_W-1:0]    cx, cy, cz;
  logic [CW-1:0]       wx, wy, wz, xm, xp, ym, yp, zm, zp;
  logic [AW-1:0]       center, addr_a, addr_b;
  logic [BW-1:0]       bd_addr;
  logic                use_bd_a, use_bd_b;
  logic [BLK_W-1:0]    rd_a, rd_b, rd_bd;
  logic                rd_vld, bd_a_q, bd_b_q;
  rd_sel_t             rd_sel_q;
  logic [BLK_W-1:0]    nb_a, nb_b, blk;
  logic [NUM_DIRS-1:0] mask, vis, vis_rest;
  logic [SIDE_W-1:0]   pick;
  logic [VTX_W-1:0]    vcount;

  // Incoming word decode.
  assign in_x     = {1'b0, cmd.pos_x};
  assign in_y     = {1'b0, cmd.pos_y};
  assign in_z     = {1'b0, cmd.pos_z};
  assign in_chunk = ({1'b0, in_x} < N_C) && ({1'b0, in_y} < N_C) && ({1'b0, in_z} < N_C);

  always_comb begin
    on_layer = 1'b0;
    ly_a     = in_x;
    ly_b     = in_y;
    case (cmd.side)
      DIR_NORTH: begin
        on_layer = (in_z == TOP_C);
      end
      DIR_SOUTH: begin
        on_layer = (in_z == '0);
      end
      DIR_WEST: begin
        on_layer = (in_x == TOP_C);
        ly_a     = in_z;
      end
      DIR_EAST: begin
        on_layer = (in_x == '0);
        ly_a     = in_z;
      end
      DIR_BOTTOM: begin
        on_layer = (in_y == TOP_C);
        ly_b     = in_z;
      end
      DIR_TOP: begin
        on_layer = (in_y == '0);
        ly_b     = in_z;
      end
      default: on_layer = 1'b0;
    endcase
  end

  assign cell_we = ctl.take && (cmd.opcode == OP_LOAD_CELL) && in_chunk;
  assign bd_we   = ctl.take && (cmd.opcode == OP_LOAD_NB) && in_chunk && on_layer;

  // Coordinates of the cell being meshed, widened below by one bit for the +1 neighbour.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cx <= cmd.pos_x;
      cy <= cmd.pos_y;
      cz <= cmd.pos_z;
    end
  end

  assign wx     = {1'b0, cx};
  assign wy     = {1'b0, cy};
  assign wz     = {1'b0, cz};
  assign xm     = wx - CW'(1);
  assign xp     = wx + CW'(1);
  assign ym     = wy - CW'(1);
  assign yp     = wy + CW'(1);
  assign zm     = wz - CW'(1);
  assign zp     = wz + CW'(1);
  assign center = cube_addr(wx, wy, wz);

  // Each neighbour read fetches one opposite pair of neighbours; at most one of them
  // can fall across the chunk edge, so the border store needs a single port.
  always_comb begin
    addr_a   = center;
    addr_b   = center;
    use_bd_a = 1'b0;
    use_bd_b = 1'b0;
    bd_addr  = layer_addr(DIR_NORTH, wx, wy);
    case (ctl.rd_sel)
      RD_CENTER: begin
        addr_a = center;
      end
      RD_NS: begin
        use_bd_a = (wz == '0);
        use_bd_b = (wz == TOP_C);
        addr_a   = use_bd_a ? center : cube_addr(wx, wy, zm);
        addr_b   = use_bd_b ? center : cube_addr(wx, wy, zp);
        bd_addr  = use_bd_a ? layer_addr(DIR_NORTH, wx, wy) : layer_addr(DIR_SOUTH, wx, wy);
      end
      RD_WE: begin
        use_bd_a = (wx == '0);
        use_bd_b = (wx == TOP_C);
        addr_a   = use_bd_a ? center : cube_addr(xm, wy, wz);
        addr_b   = use_bd_b ? center : cube_addr(xp, wy, wz);
        bd_addr  = use_bd_a ? layer_addr(DIR_WEST, wz, wy) : layer_addr(DIR_EAST, wz, wy);
      end
      RD_BT: begin
        use_bd_a = (wy == '0);
        use_bd_b = (wy == TOP_C);
        addr_a   = use_bd_a ? center : cube_addr(wx, ym, wz);
        addr_b   = use_bd_b ? center : cube_addr(wx, yp, wz);
        bd_addr  = use_bd_a ? layer_addr(DIR_BOTTOM, wx, wz) : layer_addr(DIR_TOP, wx, wz);
      end
      default: addr_a = center;
    endcase
  end

  // Cell store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cube_addr(in_x, in_y, in_z)] <= cmd.block_value;
    end
    if (ctl.rd_en) begin
      rd_a <= cell_mem[addr_a];
      rd_b <= cell_mem[addr_b];
    end
  end

  // Border store: the facing layer of each of the six neighbour chunks.
  always_ff @(posedge clk) begin
    if (bd_we) begin
      bd_mem[layer_addr(cmd.side, ly_a, ly_b)] <= cmd.block_value;
    end
    if (ctl.rd_en) begin
      rd_bd <= bd_mem[bd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctl.rd_en;
    end
    rd_sel_q <= ctl.rd_sel;
    bd_a_q   <= use_bd_a;
    bd_b_q   <= use_bd_b;
  end

  assign nb_a = bd_a_q ? rd_bd : rd_a;
  assign nb_b = bd_b_q ? rd_bd : rd_b;

  // An air cell shows no faces whatever its neighbours hold.
  assign vis      = (blk != '0) ? mask : '0;
  assign vis_rest = vis & (vis - NUM_DIRS'(1));

  always_comb begin
    pick = '0;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (vis[i]) begin
        pick = SIDE_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      case (rd_sel_q)
        RD_CENTER: blk <= rd_a;
        RD_NS: begin
          mask[0] <= (nb_a == '0);
          mask[1] <= (nb_b == '0);
        end
        RD_WE: begin
          mask[2] <= (nb_a == '0);
          mask[3] <= (nb_b == '0);
        end
        RD_BT: begin
          mask[4] <= (nb_a == '0);
          mask[5] <= (nb_b == '0);
        end
        default: blk <= rd_a;
      endcase
    end else if (ctl.emit) begin
      mask <= vis_rest;
    end
  end

  // Output word register and the running vertex counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
      vcount     <= '0;
    end else begin
      if (ctl.emit) begin
        face_valid <= 1'b1;
      end else if (!face_stall) begin
        face_valid <= 1'b0;
      end
      if (ctl.take && (cmd.opcode == OP_BEGIN)) begin
        vcount <= '0;
      end else if (ctl.emit) begin
        vcount <= vcount + VTX_STEP;
      end
    end
    if (ctl.emit) begin
      face.face_x      <= cx;
      face.face_y      <= cy;
      face.face_z      <= cz;
      face.face_dir    <= pick;
      face.block_type  <= blk;
      face.base_vertex <= vcount;
      face.last_face   <= (vis_rest == '0);
    end
  end

  assign sts.mesh_req = (cmd.opcode == OP_MESH) && in_chunk;
  assign sts.pending  = (vis != '0);
  assign sts.single   = (vis_rest == '0);
  assign sts.out_free = !face_valid || !face_stall;

endmodule

>>> rtl/vfm_ctrl.sv
`timescale 1ns / 1ps
// Controller of the mesher: sequences the neighbour reads and the face emission.
module vfm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  vfm_pkg::sts_t sts,
  output vfm_pkg::ctl_t ctl
);
  import vfm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_CELL,
    S_RD_NS,
    S_RD_WE,
    S_RD_BT,
    S_SETTLE,
    S_EMIT
  } state_t;

  state_t state, state_next;

  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.take   = cmd_valid && (state == S_IDLE);
    ctl.rd_sel = RD_CENTER;
    case (state)
      S_IDLE: begin
        if (ctl.take && sts.mesh_req) begin
          state_next = S_RD_CELL;
        end
      end
      S_RD_CELL: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_CENTER;
        state_next = S_RD_NS;
      end
      S_RD_NS: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_NS;
        state_next = S_RD_WE;
      end
      S_RD_WE: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_WE;
        state_next = S_RD_BT;
      end
      S_RD_BT: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_BT;
        state_next = S_SETTLE;
      end
      S_SETTLE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.pending) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          ctl.emit = 1'b1;
          if (sts.single) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/voxel_face_culling_mesher.sv
`timescale 1ns / 1ps
// A mesh word is accepted, then passes the read states (cell, north/south, west/east,
//   bottom/top) and a settle state before its first face word, if any, is registered.
// Load and begin words never hold the input; a mesh word holds it through four reads
//   from the dual-read cell store and one face word per cycle while face_stall is low.
// Reset (rst, synchronous, active high) clears the controller, the output valid and
//   the vertex counter; the cell and border stores are not cleared and need no pass.
// Top level of the voxel face culling mesher.
module voxel_face_culling_mesher #(
  parameter int CHUNK_SIZE = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  vfm_pkg::cmd_t  cmd,
  output logic           face_valid,
  input  logic           face_stall,
  output vfm_pkg::face_t face
);
  import vfm_pkg::*;

  // The controller accepts a word only in its idle state. Load words write the
  // cell or border store at the accepting edge, and a begin word clears the
  // vertex counter there, so neither ever holds the input.
  //
  // A mesh word walks through four reads: the cell itself, then the
  // north/south, west/east and bottom/top neighbour pairs. The cell store has two
  // read ports, one per member of a pair; a neighbour that lies across the chunk
  // edge comes from the border store instead, and only one member of a pair can.
  // After the settle state the six-bit air-neighbour mask is complete and the faces
  // leave lowest direction first, one per cycle while face_stall is low, through the
  // output register, which also lets the face stream stall without losing a word.

  ctl_t ctl;
  sts_t sts;

  vfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  vfm_datapath #(
    .CHUNK_SIZE (CHUNK_SIZE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .ctl        (ctl),
    .sts        (sts),
    .face       (face),
    .face_valid (face_valid),
    .face_stall (face_stall)
  );

endmodule

>>> rtl/vfm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the mesher and the bind that attaches them.
module vfm_props (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input vfm_pkg::cmd_t  cmd,
  input logic           face_valid,
  input logic           face_stall,
  input vfm_pkg::face_t face
);
  import vfm_pkg::*;

  // A stalled face word holds.
  a_face_hold: assert property (@(posedge clk) disable iff (rst)
    face_valid && face_stall |=> face_valid && $stable(face))
    else $error("face word changed while stalled");

  // Only a mesh word may hold the input after it is taken.
  a_no_stall_after_plain: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && (cmd.opcode != OP_MESH) |=> !cmd_stall)
    else $error("input stalled after a load or begin word");

  // A face that is not the last of its cell is followed at once by the next
  // face of the same cell, four vertices on and in a later direction.
  a_next_face: assert property (@(posedge clk) disable iff (rst)
    face_valid && !face_stall && !face.last_face |=>
      face_valid &&
      (face.base_vertex == VTX_W'($past(face.base_vertex) + VTX_STEP)) &&
      (face.face_dir > $past(face.face_dir)) &&
      (face.face_x == $past(face.face_x)))
    else $error("face sequence of a cell broken");

endmodule

bind voxel_face_culling_mesher vfm_props u_vfm_props (.*);
